/* design/stack_with_multi_pop_and_rotate_macros.svh */
// Assertion macros for the stack with multi-pop and rotate.
// Included by the files that check their own logic; needs i_clk and i_rst_n in scope.
`ifndef STACK_WITH_MULTI_POP_AND_ROTATE_MACROS_SVH
`define STACK_WITH_MULTI_POP_AND_ROTATE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWMPR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWMPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/swmpr_pkg.sv */
// Shared constants, request and status codes for the stack with multi-pop and rotate.
// No dependencies.
package swmpr_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = 5;
    localparam int WORD_W      = 32;
    localparam int REQ_W       = 3;
    localparam int STATUS_W    = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH = 3'd0,
        REQ_POP  = 3'd1,
        REQ_TOP  = 3'd2,
        REQ_POPK = 3'd3,
        REQ_ROT  = 3'd4
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

/* design/swmpr_req_if.sv */
// Request channel: valid/ready handshake with request type, push word and amount.
// Depends on swmpr_pkg.
interface swmpr_req_if;
    import swmpr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [WORD_W-1:0] push_value;
    logic [CNT_W-1:0]         amount;

    modport source (output valid, req_type, push_value, amount, input ready);
    modport sink   (input valid, req_type, push_value, amount, output ready);
endinterface

/* design/swmpr_rsp_if.sv */
// Result channel: valid/ready handshake with top word, status and item count.
// Depends on swmpr_pkg.
interface swmpr_rsp_if;
    import swmpr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] top_value;
    logic [STATUS_W-1:0]      status;
    logic [CNT_W-1:0]         item_count;

    modport source (output valid, top_value, status, item_count, input ready);
    modport sink   (input valid, top_value, status, item_count, output ready);
endinterface

/* design/swmpr_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module swmpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

/* design/stack_with_multi_pop_and_rotate.sv */
// Bounded LIFO stack with push, pop, read top, multi-pop and rotate of all held words.
// Push, pop, read top and multi-pop run through S_EXEC, S_TOP and S_LOAD into a registered
// result; rotate adds S_COPY and S_BACK, and no new item is taken until the result is loaded.
// The top word comes from the single read port of the stack RAM with registered read data.
// Synchronous active-low reset empties the stack and drops any pending result.
// Depends on swmpr_pkg, swmpr_req_if, swmpr_rsp_if, swmpr_ram and the macro header.
`include "stack_with_multi_pop_and_rotate_macros.svh"

module stack_with_multi_pop_and_rotate (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swmpr_req_if.sink  i_req,
    swmpr_rsp_if.source o_rsp
);
    import swmpr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_COPY,
        S_BACK,
        S_TOP,
        S_LOAD
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [REQ_W-1:0]    r_req_type, n_req_type;
    logic [WORD_W-1:0]   r_push_value, n_push_value;
    logic [CNT_W-1:0]    r_amount, n_amount;
    t_status             r_status, n_status;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_lower, n_lower;
    logic                r_out_valid, n_out_valid;
    logic [WORD_W-1:0]   r_out_top, n_out_top;
    t_status             r_out_status, n_out_status;
    logic [CNT_W-1:0]    r_out_count, n_out_count;

    logic                st_wr_en, st_rd_en, bf_wr_en, bf_rd_en;
    logic [ADDR_W-1:0]   st_wr_addr, st_rd_addr, bf_wr_addr, bf_rd_addr;
    logic [WORD_W-1:0]   st_wr_data, st_rd_data, bf_wr_data, bf_rd_data;

    logic [CNT_W-1:0]    cnt_m1, idx_m1, copy_src;

    assign cnt_m1   = r_count - 1'b1;
    assign idx_m1   = r_idx - 1'b1;
    assign copy_src = (r_idx < r_amount) ? (r_lower + r_idx) : (r_idx - r_amount);

    swmpr_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (st_wr_data),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_rd_data)
    );

    swmpr_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_rot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (bf_wr_en),
        .i_wr_addr (bf_wr_addr),
        .i_wr_data (bf_wr_data),
        .i_rd_en   (bf_rd_en),
        .i_rd_addr (bf_rd_addr),
        .o_rd_data (bf_rd_data)
    );

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.top_value  = $signed(r_out_top);
    assign o_rsp.status     = r_out_status;
    assign o_rsp.item_count = r_out_count;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_req_type   = r_req_type;
        n_push_value = r_push_value;
        n_amount     = r_amount;
        n_status     = r_status;
        n_idx        = r_idx;
        n_lower      = r_lower;
        n_out_valid  = r_out_valid;
        n_out_top    = r_out_top;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        st_wr_en     = 1'b0;
        st_wr_addr   = '0;
        st_wr_data   = '0;
        st_rd_en     = 1'b0;
        st_rd_addr   = '0;
        bf_wr_en     = 1'b0;
        bf_wr_addr   = '0;
        bf_wr_data   = '0;
        bf_rd_en     = 1'b0;
        bf_rd_addr   = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req_type   = i_req.req_type;
                    n_push_value = i_req.push_value;
                    n_amount     = i_req.amount;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = ST_DONE;
                n_state  = S_TOP;
                case (r_req_type)
                    REQ_PUSH: begin
                        if (r_count >= CNT_W'(STACK_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            st_wr_en   = 1'b1;
                            st_wr_addr = r_count[ADDR_W-1:0];
                            st_wr_data = r_push_value;
                            n_count    = r_count + 1'b1;
                        end
                    end
                    REQ_POP: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_count = cnt_m1;
                        end
                    end
                    REQ_TOP: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end
                    end
                    REQ_POPK: begin
                        if (r_count == '0) begin
                            if (r_amount != '0) begin
                                n_status = ST_EMPTY;
                            end
                        end else if (r_amount >= r_count) begin
                            n_count = '0;
                        end else begin
                            n_count = r_count - r_amount;
                        end
                    end
                    REQ_ROT: begin
                        if (r_amount != '0 && r_amount < r_count) begin
                            n_lower = r_count - r_amount;
                            n_idx   = '0;
                            n_state = S_COPY;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_COPY: begin
                if (r_idx < r_count) begin
                    st_rd_en   = 1'b1;
                    st_rd_addr = copy_src[ADDR_W-1:0];
                end
                if (r_idx != '0) begin
                    bf_wr_en   = 1'b1;
                    bf_wr_addr = idx_m1[ADDR_W-1:0];
                    bf_wr_data = st_rd_data;
                end
                if (r_idx == r_count) begin
                    n_idx   = '0;
                    n_state = S_BACK;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_BACK: begin
                if (r_idx < r_count) begin
                    bf_rd_en   = 1'b1;
                    bf_rd_addr = r_idx[ADDR_W-1:0];
                end
                if (r_idx != '0) begin
                    st_wr_en   = 1'b1;
                    st_wr_addr = idx_m1[ADDR_W-1:0];
                    st_wr_data = bf_rd_data;
                end
                if (r_idx == r_count) begin
                    n_idx   = '0;
                    n_state = S_TOP;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_TOP: begin
                if (r_count != '0) begin
                    st_rd_en   = 1'b1;
                    st_rd_addr = cnt_m1[ADDR_W-1:0];
                end
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_top    = (r_count == '0) ? '0 : st_rd_data;
                    n_out_status = r_status;
                    n_out_count  = r_count;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
        r_req_type   <= n_req_type;
        r_push_value <= n_push_value;
        r_amount     <= n_amount;
        r_status     <= n_status;
        r_lower      <= n_lower;
        r_out_top    <= n_out_top;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    `SWMPR_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(STACK_DEPTH),
        "item count above stack depth")
    `SWMPR_ASSERT_NEXT(a_accept_exec, i_req.valid && i_req.ready, r_state == S_EXEC,
        "accepted item not executed next cycle")
    `SWMPR_ASSERT_SAME(a_idx_bound, r_state == S_COPY || r_state == S_BACK,
        r_idx <= r_count, "rotate index beyond item count")
    `SWMPR_ASSERT_SAME(a_rot_split, r_state == S_COPY && r_idx == '0,
        r_lower != '0 && r_lower < r_count, "rotate entered with bad split")
    `SWMPR_ASSERT_NEXT(a_rot_count, r_state == S_COPY || r_state == S_BACK,
        $stable(r_count), "item count changed during rotate")
endmodule
